@@ sv/vtv_pkg.sv @@
`timescale 1ns / 1ps

package vtv_pkg;

    localparam int PIX_W      = 8;
    localparam int GRAIN_W    = 4;
    localparam int CFG_DIM_W  = 13;
    localparam int COEFF_W    = 40;
    localparam int COEFF_LO_W = 24;
    localparam int COEFF_HI_W = COEFF_W - COEFF_LO_W;
    localparam int F_W        = 17;
    localparam int PROD_W     = PIX_W + F_W;
    localparam int MAX_DIM_DEF = 4096;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_LSB = 3;
    localparam int CFG_IDX_W  = CFG_ADDR_W - CFG_IDX_LSB;

    localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = CFG_DIM_W'(640);
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = CFG_DIM_W'(480);

    // Unity vignette factor in Q16.
    localparam logic [F_W-1:0] F_ONE = F_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_COEFF  = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_SUM,
        ST_PROD,
        ST_FAC,
        ST_MUL,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic sq_en;
        logic sum_en;
        logic prod_en;
        logic fac_en;
        logic mul_en;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [PIX_W-1:0]          red_in;
        logic [PIX_W-1:0]          green_in;
        logic [PIX_W-1:0]          blue_in;
        logic [PIX_W-1:0]          alpha_in;
        logic signed [GRAIN_W-1:0] grain;
    } t_pixel;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic [PIX_W-1:0] alpha_out;
        logic             frame_end;
    } t_result;

    // Tone curve: floor(gain * (85*v + 1275) / 10000), limited to 255.
    localparam int GAIN_RED   = 110;
    localparam int GAIN_GREEN = 95;
    localparam int GAIN_BLUE  = 75;
    localparam int TONE_SCALE = 85;
    localparam int TONE_LIFT  = 1275;
    localparam int TONE_DIV   = 10000;
    localparam int PIX_MAX    = 255;

    typedef logic [PIX_W-1:0] t_tone_lut [0:255];

    function automatic t_tone_lut build_tone(input int gain);
        t_tone_lut lut;
        int        i;
        int        t;
        for (i = 0; i < 256; i++) begin
            t = (gain * (TONE_SCALE * i + TONE_LIFT)) / TONE_DIV;
            lut[i] = (t > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(t);
        end
        return lut;
    endfunction

    localparam t_tone_lut TONE_RED   = build_tone(GAIN_RED);
    localparam t_tone_lut TONE_GREEN = build_tone(GAIN_GREEN);
    localparam t_tone_lut TONE_BLUE  = build_tone(GAIN_BLUE);

endpackage

@@ sv/vtv_if.sv @@
`timescale 1ns / 1ps

interface vtv_pix_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [vtv_pkg::PIX_W-1:0]             red_in;
    logic [vtv_pkg::PIX_W-1:0]             green_in;
    logic [vtv_pkg::PIX_W-1:0]             blue_in;
    logic [vtv_pkg::PIX_W-1:0]             alpha_in;
    logic signed [vtv_pkg::GRAIN_W-1:0]    grain;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, grain, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, grain, output ready);
endinterface

interface vtv_pix_out_if;
    logic                      valid;
    logic                      ready;
    logic [vtv_pkg::PIX_W-1:0] red_out;
    logic [vtv_pkg::PIX_W-1:0] green_out;
    logic [vtv_pkg::PIX_W-1:0] blue_out;
    logic [vtv_pkg::PIX_W-1:0] alpha_out;
    logic                      frame_end;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_end,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, frame_end,
                    output ready);
endinterface

@@ sv/vtv_cfg.sv @@
`timescale 1ns / 1ps

module vtv_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [vtv_pkg::CFG_ADDR_W-1:0]      i_paddr,
    input  logic [vtv_pkg::CFG_DATA_W-1:0]      i_pwdata,
    output logic [vtv_pkg::CFG_DATA_W-1:0]      o_prdata,
    output logic                                o_pready,
    output logic [vtv_pkg::CFG_DIM_W-1:0]       o_width,
    output logic [vtv_pkg::CFG_DIM_W-1:0]       o_height,
    output logic [vtv_pkg::COEFF_W-1:0]         o_coeff
);

    logic [vtv_pkg::CFG_DIM_W-1:0] r_width;
    logic [vtv_pkg::CFG_DIM_W-1:0] r_height;
    logic [vtv_pkg::COEFF_W-1:0]   r_coeff;
    logic                          w_write;
    vtv_pkg::t_cfg_reg             w_index;

    assign o_pready = 1'b1;
    assign w_write  = i_psel && i_penable && i_pwrite;
    assign w_index  = vtv_pkg::t_cfg_reg'(i_paddr[vtv_pkg::CFG_ADDR_W-1:vtv_pkg::CFG_IDX_LSB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= vtv_pkg::WIDTH_RST;
            r_height <= vtv_pkg::HEIGHT_RST;
            r_coeff  <= '0;
        end else if (w_write) begin
            unique case (w_index)
                vtv_pkg::REG_WIDTH:  r_width  <= i_pwdata[vtv_pkg::CFG_DIM_W-1:0];
                vtv_pkg::REG_HEIGHT: r_height <= i_pwdata[vtv_pkg::CFG_DIM_W-1:0];
                vtv_pkg::REG_COEFF:  r_coeff  <= i_pwdata[vtv_pkg::COEFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            vtv_pkg::REG_WIDTH:  o_prdata = vtv_pkg::CFG_DATA_W'(r_width);
            vtv_pkg::REG_HEIGHT: o_prdata = vtv_pkg::CFG_DATA_W'(r_height);
            vtv_pkg::REG_COEFF:  o_prdata = vtv_pkg::CFG_DATA_W'(r_coeff);
            default:             o_prdata = '0;
        endcase
    end

    assign o_width  = r_width;
    assign o_height = r_height;
    assign o_coeff  = r_coeff;

endmodule

@@ sv/vtv_ctrl.sv @@
`timescale 1ns / 1ps

module vtv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output vtv_pkg::t_dp_cmd o_cmd
);

    vtv_pkg::t_state r_state;
    vtv_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_out_free;

    // The output register can take a new word when empty or being drained.
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vtv_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            vtv_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = vtv_pkg::ST_SQ;
                end
            end
            vtv_pkg::ST_SQ: begin
                o_cmd.sq_en = 1'b1;
                n_state     = vtv_pkg::ST_SUM;
            end
            vtv_pkg::ST_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = vtv_pkg::ST_PROD;
            end
            vtv_pkg::ST_PROD: begin
                o_cmd.prod_en = 1'b1;
                n_state       = vtv_pkg::ST_FAC;
            end
            vtv_pkg::ST_FAC: begin
                o_cmd.fac_en = 1'b1;
                n_state      = vtv_pkg::ST_MUL;
            end
            vtv_pkg::ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = vtv_pkg::ST_FIN;
            end
            vtv_pkg::ST_FIN: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = vtv_pkg::ST_IDLE;
                end
            end
            default: n_state = vtv_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ sv/vtv_dp.sv @@
`timescale 1ns / 1ps

module vtv_dp #(
    parameter int MAX_DIM = vtv_pkg::MAX_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vtv_pkg::t_dp_cmd                  i_cmd,
    input  vtv_pkg::t_pixel                   i_pix,
    input  logic [vtv_pkg::CFG_DIM_W-1:0]     i_width,
    input  logic [vtv_pkg::CFG_DIM_W-1:0]     i_height,
    input  logic [vtv_pkg::COEFF_W-1:0]       i_coeff,
    output vtv_pkg::t_result                  o_res
);

    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int D_W    = CNT_W + 1;
    localparam int SQ_W   = 2 * D_W;
    localparam int S_W    = SQ_W + 1;
    localparam int CMP_W  = (DIM_W > vtv_pkg::CFG_DIM_W) ? DIM_W : vtv_pkg::CFG_DIM_W;
    localparam int PHI_W  = vtv_pkg::COEFF_HI_W + S_W;
    localparam int PLO_W  = vtv_pkg::COEFF_LO_W + S_W;
    localparam int SUB_W  = PHI_W + 1;
    localparam int SUM_W  = vtv_pkg::PIX_W + 2;
    localparam int PIX_W  = vtv_pkg::PIX_W;

    function automatic logic [PIX_W-1:0] finish(input logic [vtv_pkg::PROD_W-1:0] prod,
                                                input logic signed [vtv_pkg::GRAIN_W-1:0] g);
        logic signed [SUM_W-1:0] c;
        c = signed'(SUM_W'(prod[vtv_pkg::PROD_W-1:16])) + SUM_W'(g);
        if (c < 0) begin
            return '0;
        end else if (c > signed'(SUM_W'(vtv_pkg::PIX_MAX))) begin
            return PIX_W'(vtv_pkg::PIX_MAX);
        end else begin
            return c[PIX_W-1:0];
        end
    endfunction

    function automatic logic [DIM_W-1:0] eff_dim(input logic [vtv_pkg::CFG_DIM_W-1:0] d);
        logic [CMP_W-1:0] x;
        x = CMP_W'(d);
        if (x == '0) begin
            return DIM_W'(1);
        end else if (x > CMP_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end else begin
            return DIM_W'(x);
        end
    endfunction

    function automatic logic [D_W-1:0] abs_diff(input logic [CNT_W-1:0] cnt,
                                                input logic [DIM_W-1:0] dim);
        logic [D_W-1:0] twice;
        logic [D_W-1:0] dd;
        twice = {cnt, 1'b0};
        dd    = D_W'(dim);
        return (twice >= dd) ? (twice - dd) : (dd - twice);
    endfunction

    logic [CNT_W-1:0]                    r_col;
    logic [CNT_W-1:0]                    r_row;
    logic [DIM_W-1:0]                    w_eff_w;
    logic [DIM_W-1:0]                    w_eff_h;
    logic                                w_row_end;
    logic                                w_last;

    logic [D_W-1:0]                      r_dx;
    logic [D_W-1:0]                      r_dy;
    logic                                r_last;
    logic [PIX_W-1:0]                    r_tone_r;
    logic [PIX_W-1:0]                    r_tone_g;
    logic [PIX_W-1:0]                    r_tone_b;
    logic [PIX_W-1:0]                    r_alpha;
    logic signed [vtv_pkg::GRAIN_W-1:0]  r_grain;
    logic [SQ_W-1:0]                     r_sqx;
    logic [SQ_W-1:0]                     r_sqy;
    logic [S_W-1:0]                      r_s;
    logic [PHI_W-1:0]                    r_phi;
    logic [PLO_W-1:0]                    r_plo;
    logic [SUB_W-1:0]                    w_sub;
    logic [vtv_pkg::F_W-1:0]             r_f;
    logic [vtv_pkg::PROD_W-1:0]          r_pr_r;
    logic [vtv_pkg::PROD_W-1:0]          r_pr_g;
    logic [vtv_pkg::PROD_W-1:0]          r_pr_b;
    vtv_pkg::t_result                    r_res;

    assign w_eff_w   = eff_dim(i_width);
    assign w_eff_h   = eff_dim(i_height);
    assign w_row_end = (D_W'(r_col) + D_W'(1)) >= D_W'(w_eff_w);
    assign w_last    = w_row_end && ((D_W'(r_row) + D_W'(1)) >= D_W'(w_eff_h));

    // Pixel position; the last column, or one past the frame size, closes the row, and the last row closes the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.load) begin
            if (w_row_end) begin
                r_col <= '0;
                r_row <= w_last ? '0 : r_row + CNT_W'(1);
            end else begin
                r_col <= r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx     <= abs_diff(r_col, w_eff_w);
            r_dy     <= abs_diff(r_row, w_eff_h);
            r_last   <= w_last;
            r_tone_r <= vtv_pkg::TONE_RED[i_pix.red_in];
            r_tone_g <= vtv_pkg::TONE_GREEN[i_pix.green_in];
            r_tone_b <= vtv_pkg::TONE_BLUE[i_pix.blue_in];
            r_alpha  <= i_pix.alpha_in;
            r_grain  <= i_pix.grain;
        end
        if (i_cmd.sq_en) begin
            r_sqx <= SQ_W'(r_dx) * SQ_W'(r_dx);
            r_sqy <= SQ_W'(r_dy) * SQ_W'(r_dy);
        end
        if (i_cmd.sum_en) begin
            r_s <= S_W'(r_sqx) + S_W'(r_sqy);
        end
        // The 40-bit coefficient is split so each product stays a modest multiplier.
        if (i_cmd.prod_en) begin
            r_phi <= PHI_W'(i_coeff[vtv_pkg::COEFF_W-1:vtv_pkg::COEFF_LO_W]) * PHI_W'(r_s);
            r_plo <= PLO_W'(i_coeff[vtv_pkg::COEFF_LO_W-1:0]) * PLO_W'(r_s);
        end
        if (i_cmd.fac_en) begin
            r_f <= (w_sub >= SUB_W'(vtv_pkg::F_ONE)) ? '0
                 : vtv_pkg::F_ONE - w_sub[vtv_pkg::F_W-1:0];
        end
        if (i_cmd.mul_en) begin
            r_pr_r <= vtv_pkg::PROD_W'(r_tone_r) * vtv_pkg::PROD_W'(r_f);
            r_pr_g <= vtv_pkg::PROD_W'(r_tone_g) * vtv_pkg::PROD_W'(r_f);
            r_pr_b <= vtv_pkg::PROD_W'(r_tone_b) * vtv_pkg::PROD_W'(r_f);
        end
        if (i_cmd.out_load) begin
            r_res.red_out   <= finish(r_pr_r, r_grain);
            r_res.green_out <= finish(r_pr_g, r_grain);
            r_res.blue_out  <= finish(r_pr_b, r_grain);
            r_res.alpha_out <= r_alpha;
            r_res.frame_end <= r_last;
        end
    end

    assign w_sub = SUB_W'(r_phi) + SUB_W'(r_plo[PLO_W-1:vtv_pkg::COEFF_LO_W]);
    assign o_res = r_res;

endmodule

@@ sv/vintage_tone_vignette_pixel.sv @@
`timescale 1ns / 1ps

// Warm tone and vignette filter for an RGBA pixel stream in raster order. Each
// pixel occupies the datapath alone: the word is accepted in the idle state and
// its result is loaded into the output register in the final state, as the
// controller walks one pixel through the datapath steps (position offsets and
// tone lookup, two squares, distance sum, split coefficient multiply, vignette
// factor, channel multiply, grain and clamp), so the input takes no new word
// until that result is loaded. The output register holds a finished word
// while the next pixel is already being worked on; a stalled output holds the
// last step until the register frees up. The column and row counters are never
// cleared by register writes, and width, height and the vignette coefficient
// must be written only while the block is idle. A width or height of zero acts
// as one.
module vintage_tone_vignette_pixel #(
    parameter int MAX_DIM = vtv_pkg::MAX_DIM_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    vtv_pix_in_if.sink                     i_pix,
    vtv_pix_out_if.source                  o_pix,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vtv_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [vtv_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [vtv_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [vtv_pkg::CFG_DIM_W-1:0] w_width;
    logic [vtv_pkg::CFG_DIM_W-1:0] w_height;
    logic [vtv_pkg::COEFF_W-1:0]   w_coeff;
    vtv_pkg::t_dp_cmd              w_cmd;
    vtv_pkg::t_pixel               w_pix;
    vtv_pkg::t_result              w_res;
    logic                          w_in_ready;
    logic                          w_out_valid;

    assign w_pix.red_in   = i_pix.red_in;
    assign w_pix.green_in = i_pix.green_in;
    assign w_pix.blue_in  = i_pix.blue_in;
    assign w_pix.alpha_in = i_pix.alpha_in;
    assign w_pix.grain    = i_pix.grain;
    assign i_pix.ready    = w_in_ready;

    assign o_pix.valid     = w_out_valid;
    assign o_pix.red_out   = w_res.red_out;
    assign o_pix.green_out = w_res.green_out;
    assign o_pix.blue_out  = w_res.blue_out;
    assign o_pix.alpha_out = w_res.alpha_out;
    assign o_pix.frame_end = w_res.frame_end;

    vtv_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_width   (w_width),
        .o_height  (w_height),
        .o_coeff   (w_coeff)
    );

    vtv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_out_ready (o_pix.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    vtv_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_pix    (w_pix),
        .i_width  (w_width),
        .i_height (w_height),
        .i_coeff  (w_coeff),
        .o_res    (w_res)
    );

endmodule

@@ dv/vintage_tone_vignette_pixel_checker.sv @@
`timescale 1ns / 1ps

module vintage_tone_vignette_pixel_checker
    import vtv_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vtv_pix_in_if                 i_pix,
    vtv_pix_out_if                i_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    o_mismatches,
    output int                    o_pending
);

    logic [CFG_DIM_W-1:0] frame_w;
    logic [CFG_DIM_W-1:0] frame_h;
    logic [COEFF_W-1:0]   vig_coeff;
    int                   col_pos;
    int                   row_pos;
    t_result              shaded_q[$];
    int                   mismatch_count = 0;
    int                   pending_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
    endtask

    function automatic int clip_dim(logic [CFG_DIM_W-1:0] d);
        if (d == 0) begin
            return 1;
        end
        if (d > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(d);
    endfunction

    function automatic logic [PIX_W-1:0] warm_tone(logic [PIX_W-1:0] v, int gain);
        int t;
        t = gain * (TONE_SCALE * int'(v) + TONE_LIFT) / TONE_DIV;
        return (t > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(t);
    endfunction

    function automatic longint unsigned offset_sq(int twice, int dim);
        longint d;
        d = longint'(twice) - longint'(dim);
        return longint'(d * d);
    endfunction

    function automatic logic [PIX_W-1:0] grade_channel(logic [PIX_W-1:0] t,
                                                       logic [F_W-1:0] fac,
                                                       logic signed [GRAIN_W-1:0] g);
        int c;
        c = int'((longint'(t) * longint'(fac)) >> (F_W - 1)) + int'(g);
        if (c < 0) begin
            c = 0;
        end
        if (c > PIX_MAX) begin
            c = PIX_MAX;
        end
        return PIX_W'(c);
    endfunction

    // The coefficient is split at bit 24 so that the product with the squared
    // distance fits in 64 bits without losing the low fraction.
    function automatic t_result shade_pixel(t_pixel px);
        t_result         r;
        int              w;
        int              h;
        longint unsigned s;
        longint unsigned sub;
        logic [F_W-1:0]  fac;
        w = clip_dim(frame_w);
        h = clip_dim(frame_h);
        s = offset_sq(2 * col_pos, w) + offset_sq(2 * row_pos, h);
        sub = 64'(vig_coeff[COEFF_W-1:COEFF_LO_W]) * s
            + ((64'(vig_coeff[COEFF_LO_W-1:0]) * s) >> COEFF_LO_W);
        fac = (sub >= 64'(F_ONE)) ? '0 : F_W'(64'(F_ONE) - sub);
        r.red_out   = grade_channel(warm_tone(px.red_in, GAIN_RED), fac, px.grain);
        r.green_out = grade_channel(warm_tone(px.green_in, GAIN_GREEN), fac, px.grain);
        r.blue_out  = grade_channel(warm_tone(px.blue_in, GAIN_BLUE), fac, px.grain);
        r.alpha_out = px.alpha_in;
        r.frame_end = (col_pos + 1 >= w) && (row_pos + 1 >= h);
        return r;
    endfunction

    task automatic step_position();
        int w;
        int h;
        w = clip_dim(frame_w);
        h = clip_dim(frame_h);
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_pixel  px;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            frame_w   = WIDTH_RST;
            frame_h   = HEIGHT_RST;
            vig_coeff = '0;
            col_pos   = 0;
            row_pos   = 0;
            shaded_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_ADDR_W-1:CFG_IDX_LSB])
                    REG_WIDTH:  frame_w = pwdata[CFG_DIM_W-1:0];
                    REG_HEIGHT: frame_h = pwdata[CFG_DIM_W-1:0];
                    REG_COEFF:  vig_coeff = pwdata[COEFF_W-1:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                got.red_out   = i_res.red_out;
                got.green_out = i_res.green_out;
                got.blue_out  = i_res.blue_out;
                got.alpha_out = i_res.alpha_out;
                got.frame_end = i_res.frame_end;
                if (shaded_q.size() == 0) begin
                    report_mismatch("result word with nothing pending, red", got.red_out, -1);
                end else begin
                    want = shaded_q.pop_front();
                    if (got.red_out !== want.red_out)
                        report_mismatch("red", got.red_out, want.red_out);
                    if (got.green_out !== want.green_out)
                        report_mismatch("green", got.green_out, want.green_out);
                    if (got.blue_out !== want.blue_out)
                        report_mismatch("blue", got.blue_out, want.blue_out);
                    if (got.alpha_out !== want.alpha_out)
                        report_mismatch("alpha", got.alpha_out, want.alpha_out);
                    if (got.frame_end !== want.frame_end)
                        report_mismatch("frame_end", got.frame_end, want.frame_end);
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                px.red_in   = i_pix.red_in;
                px.green_in = i_pix.green_in;
                px.blue_in  = i_pix.blue_in;
                px.alpha_in = i_pix.alpha_in;
                px.grain    = i_pix.grain;
                shaded_q.push_back(shade_pixel(px));
                step_position();
            end
        end
        pending_count = shaded_q.size();
    end

endmodule

@@ dv/vintage_tone_vignette_pixel_tb.sv @@
`timescale 1ns / 1ps

module vintage_tone_vignette_pixel_tb;
    import vtv_pkg::*;

    localparam int                    MAX_DIM    = MAX_DIM_DEF;
    localparam logic [CFG_IDX_W-1:0]  REG_SPARE  = CFG_IDX_W'(3);
    localparam logic [COEFF_W-1:0]    COEFF_FULL = '1;
    localparam int                    RUN_PHASES = 10;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    mismatches;
    int                    pending;
    int                    gap_odds;
    int                    stall_odds;

    vtv_pix_in_if  pix_in();
    vtv_pix_out_if pix_out();

    vintage_tone_vignette_pixel #(
        .MAX_DIM(MAX_DIM)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    vintage_tone_vignette_pixel_checker #(
        .MAX_DIM(MAX_DIM)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_in),
        .i_res        (pix_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("vintage_tone_vignette_pixel_tb: errors");
        $finish;
    end

    // The sink side stalls in bursts whenever stall_odds is nonzero.
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                pix_out.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            pix_out.ready <= 1'b1;
        end
    end

    function automatic t_pixel pixel_of(int r, int g, int b, int a, int gr);
        t_pixel px;
        px.red_in   = PIX_W'(r);
        px.green_in = PIX_W'(g);
        px.blue_in  = PIX_W'(b);
        px.alpha_in = PIX_W'(a);
        px.grain    = GRAIN_W'(gr);
        return px;
    endfunction

    function automatic logic [PIX_W-1:0] random_level();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel px;
        px.red_in   = random_level();
        px.green_in = random_level();
        px.blue_in  = random_level();
        px.alpha_in = random_level();
        if ($urandom_range(0, 7) == 0) begin
            px.grain = GRAIN_W'($urandom_range(0, 15));
        end else begin
            px.grain = GRAIN_W'(int'($urandom_range(0, 12)) - 6);
        end
        return px;
    endfunction

    // Coefficient as software would set it for a frame: 0.55 * 2^40 / (W^2 + H^2).
    function automatic logic [COEFF_W-1:0] vignette_for(int w, int h);
        longint unsigned d;
        w = (w == 0) ? 1 : ((w > MAX_DIM) ? MAX_DIM : w);
        h = (h == 0) ? 1 : ((h > MAX_DIM) ? MAX_DIM : h);
        d = longint'(w) * w + longint'(h) * h;
        return COEFF_W'(((64'd11 << 40) + 10 * d) / (20 * d));
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx) << CFG_IDX_LSB;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_pixel(t_pixel px);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.red_in   <= px.red_in;
        pix_in.green_in <= px.green_in;
        pix_in.blue_in  <= px.blue_in;
        pix_in.alpha_in <= px.alpha_in;
        pix_in.grain    <= px.grain;
        do @(posedge i_clk); while (!pix_in.ready);
        @(negedge i_clk);
    endtask

    // Every word has a result, so an empty queue means the block is idle; the
    // extra cycles cover the pipeline tail.
    task automatic drain();
        pix_in.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (24) @(negedge i_clk);
    endtask

    initial begin
        logic [CFG_DIM_W-1:0] w;
        logic [CFG_DIM_W-1:0] h;
        logic [COEFF_W-1:0]   k;
        int                   n;

        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        pix_in.valid    = 1'b0;
        pix_in.red_in   = '0;
        pix_in.green_in = '0;
        pix_in.blue_in  = '0;
        pix_in.alpha_in = '0;
        pix_in.grain    = '0;
        pix_out.ready   = 1'b0;
        gap_odds        = 4;
        stall_odds      = 4;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset sizes and a zero coefficient: the tone curve and grain alone.
        send_pixel(pixel_of(0, 0, 0, 0, 0));
        send_pixel(pixel_of(255, 255, 255, 255, 7));
        send_pixel(pixel_of(8'hAA, 8'h55, 8'h0F, 8'hF0, -7));
        send_pixel(pixel_of(8'h55, 8'hAA, 8'hF0, 8'h0F, 6));
        send_pixel(pixel_of(1, 128, 254, 127, -6));
        send_pixel(pixel_of(200, 100, 50, 25, -8));
        drain();

        // A 3x2 frame, one full frame and a wrap; the spare address is ignored.
        cfg_write(REG_WIDTH, 3);
        cfg_write(REG_HEIGHT, 2);
        cfg_write(REG_COEFF, vignette_for(3, 2));
        cfg_write(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_pixel(pixel_of(255, 255, 255, 255, 0));
        send_pixel(pixel_of(255, 255, 255, 0, -8));
        send_pixel(pixel_of(128, 128, 128, 255, 5));
        send_pixel(pixel_of(255, 255, 255, 1, 0));
        send_pixel(pixel_of(10, 20, 30, 40, -3));
        send_pixel(pixel_of(255, 0, 255, 0, 7));
        send_pixel(pixel_of(0, 255, 0, 255, 0));
        drain();

        // Zero sizes act as one, and a full coefficient drives the factor to zero.
        cfg_write(REG_WIDTH, 0);
        cfg_write(REG_HEIGHT, 0);
        cfg_write(REG_COEFF, COEFF_FULL);
        send_pixel(pixel_of(255, 255, 255, 255, -8));
        send_pixel(pixel_of(255, 255, 255, 255, 7));
        send_pixel(pixel_of(0, 0, 0, 0, 3));
        drain();

        // Sizes beyond the maximum are limited to it.
        cfg_write(REG_WIDTH, 13'h1FFF);
        cfg_write(REG_HEIGHT, 4097);
        cfg_write(REG_COEFF, vignette_for(8191, 4097));
        send_pixel(pixel_of(90, 180, 45, 200, 2));
        send_pixel(pixel_of(255, 255, 255, 255, -1));
        send_pixel(pixel_of(0, 0, 0, 0, -6));

        for (int ph = 0; ph < RUN_PHASES; ph++) begin
            n = 140;
            w = CFG_DIM_W'($urandom_range(1, 24));
            h = CFG_DIM_W'($urandom_range(1, 24));
            k = vignette_for(w, h) * $urandom_range(1, 4);
            case (ph)
                0: begin
                    w = CFG_DIM_W'($urandom_range(1, 8));
                    h = CFG_DIM_W'($urandom_range(1, 8));
                    k = vignette_for(w, h);
                end
                1: begin
                    w = CFG_DIM_W'(1);
                    h = CFG_DIM_W'($urandom_range(1, 4));
                    k = vignette_for(w, h);
                end
                2: k = COEFF_W'({$urandom, $urandom});
                3: begin
                    w = CFG_DIM_W'(MAX_DIM);
                    h = CFG_DIM_W'(MAX_DIM);
                    k = vignette_for(w, h);
                    n = 40;
                end
                4: k = '0;
                5: begin
                    w = CFG_DIM_W'($urandom_range(0, 8191));
                    h = CFG_DIM_W'($urandom_range(0, 8191));
                    k = vignette_for(w, h) * $urandom_range(1, 3);
                    n = 60;
                end
                default: ;
            endcase
            gap_odds   = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 3 : 8);
            stall_odds = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 8 : 3);
            if (ph >= RUN_PHASES - 2) begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            drain();
            // Later phases sometimes keep a size, so a frame runs on across phases.
            if (ph < 3 || $urandom_range(0, 3) != 0) cfg_write(REG_WIDTH, w);
            if (ph < 3 || $urandom_range(0, 3) != 0) cfg_write(REG_HEIGHT, h);
            if (ph < 3 || $urandom_range(0, 3) != 0) cfg_write(REG_COEFF, k);
            for (int i = 0; i < n; i++) begin
                send_pixel(random_pixel());
                if (ph == 7 && i == n / 2) begin
                    drain();
                end
            end
        end

        drain();
        if (mismatches == 0 && pending == 0) begin
            $display("vintage_tone_vignette_pixel_tb: clean");
        end else begin
            $display("vintage_tone_vignette_pixel_tb: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/vtv_pkg.sv
sv/vtv_if.sv
sv/vtv_cfg.sv
sv/vtv_ctrl.sv
sv/vtv_dp.sv
sv/vintage_tone_vignette_pixel.sv
dv/vintage_tone_vignette_pixel_checker.sv
dv/vintage_tone_vignette_pixel_tb.sv
